>>> hdl/imu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pkg
// Shared types and codes of the integer math unit.
// ----------------------------------------------------------------------------
package imu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int KIND_WIDTH = 4;
  localparam int ERR_WIDTH  = 2;

  localparam logic [KIND_WIDTH-1:0] KIND_ADD  = 4'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_SUB  = 4'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_MUL  = 4'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_DIV  = 4'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_MOD  = 4'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_POW  = 4'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_ABS  = 4'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_MIN  = 4'd7;
  localparam logic [KIND_WIDTH-1:0] KIND_MAX  = 4'd8;
  localparam logic [KIND_WIDTH-1:0] KIND_FACT = 4'd9;
  localparam logic [KIND_WIDTH-1:0] KIND_SQRT = 4'd10;

  localparam logic [ERR_WIDTH-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_WIDTH-1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [ERR_WIDTH-1:0] ERR_NEG_ARG  = 2'd2;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
  } imu_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result_value;
    logic [ERR_WIDTH-1:0]  error_code;
  } imu_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } imu_status_t;

endpackage

>>> hdl/imu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_core
// Sequencer around one multiplier and one subtractor that runs every
// operation of the integer math unit, one request at a time.
// ----------------------------------------------------------------------------
module imu_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  imu_pkg::imu_req_t    req,
  output imu_pkg::imu_status_t status,
  output imu_pkg::imu_rsp_t    rsp
);

  localparam int W = imu_pkg::DATA_WIDTH;
  localparam int DIV_STEPS = W;
  localparam int ROOT_STEPS = W / 2;
  localparam int CW = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t                          state;
  logic [imu_pkg::KIND_WIDTH-1:0]  kind;
  logic [W-1:0]                    a;
  logic [W-1:0]                    b;
  logic [W-1:0]                    acc;   // product, quotient or root radicand
  logic [W-1:0]                    base;  // base, counter i or divisor
  logic [W-1:0]                    rem;
  logic [ROOT_STEPS-1:0]           root;
  logic [CW-1:0]                   cnt;
  logic                            phase;
  logic [imu_pkg::ERR_WIDTH-1:0]   err;

  logic [W-1:0] mul_x, mul_y, prod;
  logic [W-1:0] sub_x, sub_y;
  logic [W:0]   diff;
  logic [W-1:0] mag_a, mag_b;
  logic [W-1:0] res_mux;

  assign mag_a = req.operand_a[W-1] ? (~req.operand_a + 1'b1) : req.operand_a;
  assign mag_b = req.operand_b[W-1] ? (~req.operand_b + 1'b1) : req.operand_b;

  // shared multiplier, low word only
  always_comb begin
    mul_x = acc;
    mul_y = base;
    if (state == ST_FIN) begin
      mul_x = a;
      mul_y = b;
    end else if (kind == imu_pkg::KIND_POW && phase) begin
      mul_x = base;
    end
  end
  assign prod = mul_x * mul_y;

  // shared subtractor: divide step or root step
  always_comb begin
    if (kind == imu_pkg::KIND_SQRT) begin
      sub_x = {rem[W-3:0], acc[W-1:W-2]};
      sub_y = {{(W-ROOT_STEPS-2){1'b0}}, root, 2'b01};
    end else begin
      sub_x = {rem[W-2:0], acc[W-1]};
      sub_y = base;
    end
  end
  assign diff = {1'b0, sub_x} - {1'b0, sub_y};

  always_comb begin
    case (kind)
      imu_pkg::KIND_ADD:  res_mux = a + b;
      imu_pkg::KIND_SUB:  res_mux = a - b;
      imu_pkg::KIND_MUL:  res_mux = prod;
      imu_pkg::KIND_DIV:  res_mux = (a[W-1] ^ b[W-1]) ? (~acc + 1'b1) : acc;
      imu_pkg::KIND_MOD:  res_mux = a[W-1] ? (~rem + 1'b1) : rem;
      imu_pkg::KIND_POW:  res_mux = acc;
      imu_pkg::KIND_ABS:  res_mux = a[W-1] ? (~a + 1'b1) : a;
      imu_pkg::KIND_MIN:  res_mux = ($signed(a) < $signed(b)) ? a : b;
      imu_pkg::KIND_MAX:  res_mux = ($signed(b) < $signed(a)) ? a : b;
      imu_pkg::KIND_FACT: res_mux = acc;
      imu_pkg::KIND_SQRT: res_mux = {{(W-ROOT_STEPS){1'b0}}, root};
      default:            res_mux = '0;
    endcase
  end

  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_FIN);
  assign rsp.result_value = (err != imu_pkg::ERR_NONE) ? '0 : res_mux;
  assign rsp.error_code = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
      cnt   <= '0;
      err   <= imu_pkg::ERR_NONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            kind  <= req.kind;
            a     <= req.operand_a;
            b     <= req.operand_b;
            acc   <= {{(W-1){1'b0}}, 1'b1};
            base  <= req.operand_a;
            rem   <= '0;
            root  <= '0;
            phase <= 1'b0;
            err   <= imu_pkg::ERR_NONE;
            state <= ST_FIN;
            case (req.kind)
              imu_pkg::KIND_DIV, imu_pkg::KIND_MOD: begin
                if (req.operand_b == '0) begin
                  err <= imu_pkg::ERR_ZERO_DIV;
                end else begin
                  acc   <= mag_a;
                  base  <= mag_b;
                  cnt   <= CW'(DIV_STEPS);
                  state <= ST_RUN;
                end
              end
              imu_pkg::KIND_POW: begin
                if (req.operand_b[W-1]) err <= imu_pkg::ERR_NEG_ARG;
                else state <= ST_RUN;
              end
              imu_pkg::KIND_FACT: begin
                base <= W'(2);
                if (req.operand_a[W-1]) err <= imu_pkg::ERR_NEG_ARG;
                else state <= ST_RUN;
              end
              imu_pkg::KIND_SQRT: begin
                acc <= req.operand_a;
                cnt <= CW'(ROOT_STEPS);
                if (req.operand_a[W-1]) err <= imu_pkg::ERR_NEG_ARG;
                else state <= ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          case (kind)
            imu_pkg::KIND_POW: begin
              if (!phase) begin
                if (b == '0) state <= ST_FIN;
                else begin
                  if (b[0]) acc <= prod;
                  phase <= 1'b1;
                end
              end else begin
                base  <= prod;
                b     <= b >> 1;
                phase <= 1'b0;
              end
            end
            imu_pkg::KIND_FACT: begin
              if (base > a || acc == '0) state <= ST_FIN;
              else begin
                acc  <= prod;
                base <= base + 1'b1;
              end
            end
            imu_pkg::KIND_SQRT: begin
              acc <= acc << 2;
              if (!diff[W]) begin
                rem  <= diff[W-1:0];
                root <= {root[ROOT_STEPS-2:0], 1'b1};
              end else begin
                rem  <= sub_x;
                root <= {root[ROOT_STEPS-2:0], 1'b0};
              end
              cnt <= cnt - 1'b1;
              if (cnt == CW'(1)) state <= ST_FIN;
            end
            default: begin
              // restoring divide step on magnitudes
              if (!diff[W]) begin
                rem <= diff[W-1:0];
                acc <= {acc[W-2:0], 1'b1};
              end else begin
                rem <= sub_x;
                acc <= {acc[W-2:0], 1'b0};
              end
              cnt <= cnt - 1'b1;
              if (cnt == CW'(1)) state <= ST_FIN;
            end
          endcase
        end
        ST_FIN: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/integer_math_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_math_unit
// 32-bit signed integer unit: add, sub, mul, div, mod, pow, abs, min, max,
// factorial and floor square root, with wrapped results and an error code.
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while the core is idle and the
// result register is empty. Add, sub, mul, abs, min, max, unused codes and
// error cases go from the accepting edge straight to the finish state; div and
// mod run one radix-2 step of the shared subtractor per quotient bit; sqrt runs
// one step per root bit; pow makes two passes through the shared multiplier per
// exponent bit; factorial stops early once the wrapped product reaches zero,
// which it does by the factor 34.
module integer_math_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  s_tuser,   // [3:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] result_value
  output logic [1:0]  m_tuser    // [1:0] error_code
);

  imu_pkg::imu_req_t    req;
  imu_pkg::imu_rsp_t    rsp;
  imu_pkg::imu_status_t status;
  logic                 start;

  assign s_tready = !status.busy && !m_tvalid;
  assign start = s_tvalid && s_tready;
  assign req.kind = s_tuser;
  assign req.operand_a = s_tdata[31:0];
  assign req.operand_b = s_tdata[63:32];

  imu_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= rsp.result_value;
      m_tuser  <= rsp.error_code;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> status.busy) else $error("core not busy after transfer");

  a_done_into_empty: assert property (@(posedge clk) disable iff (rst)
    status.done |-> !m_tvalid) else $error("result overwrites pending output");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != imu_pkg::ERR_NONE) |-> m_tdata == '0)
    else $error("nonzero result with error");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while output pending");

endmodule
